>>> sv/kuf_pkg.sv
// Shared widths, codes and control/status bundles for the union-find edge filter.
package kuf_pkg;

  localparam int VERTEX_W         = 8;    // width of an endpoint field
  localparam int COUNT_W          = 9;    // width of the vertex_count register
  localparam int RANK_W           = 4;    // width of a stored rank
  localparam int TREE_W           = 8;    // width of the tree edge count
  localparam int MAX_VERTICES_DEF = 256;  // default store depth

  localparam logic [COUNT_W-1:0] VCOUNT_RESET = 9'd256;

  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_EDGE  = 1'b1;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_CYCLE    = 3'd1,
    ST_FULL     = 3'd2,
    ST_RANGE    = 3'd3,
    ST_CLEARED  = 3'd4
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic    load_item;    // latch the accepted beat
    logic    sweep_start;  // restart the clearing counter
    logic    sweep_wr;     // write one self-pointing entry, advance counter
    logic    clr_count;    // zero the tree edge count
    logic    cur_load;     // cursor <- endpoint chosen by sel_b
    logic    sel_b;        // endpoint / root slot select
    logic    walk_step;    // cursor <- parent read back
    logic    root_save;    // record cursor and its rank as the root
    logic    comp_wr;      // re-point cursor at root, cursor <- old parent
    logic    join_wr;      // hang the lower-rank root under the other
    logic    rank_wr;      // bump the surviving root's rank
    logic    count_inc;    // one more tree edge
    logic    status_load;  // latch status code below
    status_t status;
    logic    out_load;     // load the output registers
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_clear;
    logic tree_full;
    logic out_of_range;
    logic at_root;
    logic cur_is_root;
    logic roots_equal;
    logic ranks_equal;
    logic rank_a_max;
    logic sweep_last;
  } stat_t;

endpackage

>>> sv/kuf_in_if.sv
// Input channel: operation and edge endpoints with valid/ready handshake.
interface kuf_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [kuf_pkg::VERTEX_W-1:0]  vertex_a;
  logic [kuf_pkg::VERTEX_W-1:0]  vertex_b;
  logic                          last_edge;

  modport source (output valid, operation, vertex_a, vertex_b, last_edge, input ready);
  modport sink   (input valid, operation, vertex_a, vertex_b, last_edge, output ready);
endinterface

>>> sv/kuf_out_if.sv
// Result channel: status, tree edge count and finished flag with valid/ready.
interface kuf_out_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  status;
  logic [kuf_pkg::TREE_W-1:0]  tree_edges;
  logic                        finished;

  modport source (output valid, status, tree_edges, finished, input ready);
  modport sink   (input valid, status, tree_edges, finished, output ready);
endinterface

>>> sv/kuf_dp.sv
// Datapath: parent/rank memory, find cursor, roots, tree count, output registers.
module kuf_dp #(
  parameter int MAX_VERTICES = kuf_pkg::MAX_VERTICES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [kuf_pkg::COUNT_W-1:0]   cfg_wdata,
  input  logic                          in_operation,
  input  logic [kuf_pkg::VERTEX_W-1:0]  in_vertex_a,
  input  logic [kuf_pkg::VERTEX_W-1:0]  in_vertex_b,
  input  logic                          in_last_edge,
  input  kuf_pkg::cmd_t                 cmd,
  output kuf_pkg::stat_t                stat,
  output logic [2:0]                    out_status,
  output logic [kuf_pkg::TREE_W-1:0]    out_tree_edges,
  output logic                          out_finished
);

  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int RW    = kuf_pkg::RANK_W;
  localparam int CW    = kuf_pkg::COUNT_W;
  localparam int MEM_W = VW + RW;
  localparam int CAP   = (MAX_VERTICES > 511) ? 511 : MAX_VERTICES;
  localparam logic [CW-1:0] N_CAP     = CW'(CAP);
  localparam logic [VW-1:0] LAST_ADDR = VW'(MAX_VERTICES - 1);

  logic [MEM_W-1:0] mem [MAX_VERTICES];
  logic [MEM_W-1:0] rdata_r;
  logic             we;
  logic [VW-1:0]    waddr;
  logic [MEM_W-1:0] wdata;

  logic [CW-1:0]                 vcount_r;
  logic [VW-1:0]                 sweep_cnt_r;
  logic [kuf_pkg::TREE_W-1:0]    acc_r;
  logic                          op_r;
  logic                          last_r;
  logic [kuf_pkg::VERTEX_W-1:0]  a_r, b_r;
  logic [VW-1:0]                 cur_r;
  logic [VW-1:0]                 root_a_r, root_b_r;
  logic [RW-1:0]                 rank_a_r, rank_b_r;
  kuf_pkg::status_t              status_r;
  kuf_pkg::status_t              out_status_r;
  logic [kuf_pkg::TREE_W-1:0]    out_tree_r;
  logic                          out_fin_r;

  logic [VW-1:0] rd_parent;
  logic [RW-1:0] rd_rank;
  logic [CW-1:0] n_eff, limit;
  logic [VW-1:0] a_idx, b_idx;
  logic          full_now;

  assign rd_parent = rdata_r[VW-1:0];
  assign rd_rank   = rdata_r[MEM_W-1:VW];
  assign a_idx     = VW'(a_r);
  assign b_idx     = VW'(b_r);

  assign n_eff    = (vcount_r < N_CAP) ? vcount_r : N_CAP;
  assign limit    = (n_eff == '0) ? '0 : n_eff - 1'b1;
  assign full_now = ({1'b0, acc_r} >= limit);

  assign stat.is_clear     = (op_r == kuf_pkg::OP_CLEAR);
  assign stat.tree_full    = full_now;
  assign stat.out_of_range = ({1'b0, a_r} >= n_eff) || ({1'b0, b_r} >= n_eff);
  assign stat.at_root      = (rd_parent == cur_r);
  assign stat.cur_is_root  = (cur_r == (cmd.sel_b ? root_b_r : root_a_r));
  assign stat.roots_equal  = (root_a_r == root_b_r);
  assign stat.ranks_equal  = (rank_a_r == rank_b_r);
  assign stat.rank_a_max   = (rank_a_r == '1);
  assign stat.sweep_last   = (sweep_cnt_r == LAST_ADDR);

  // single write port mux
  always_comb begin
    we    = 1'b0;
    waddr = cur_r;
    wdata = {rd_rank, root_a_r};
    priority if (cmd.sweep_wr) begin
      we    = 1'b1;
      waddr = sweep_cnt_r;
      wdata = {{RW{1'b0}}, sweep_cnt_r};
    end else if (cmd.comp_wr) begin
      we    = 1'b1;
      waddr = cur_r;
      wdata = {rd_rank, cmd.sel_b ? root_b_r : root_a_r};
    end else if (cmd.join_wr) begin
      we = 1'b1;
      if (rank_a_r < rank_b_r) begin
        waddr = root_a_r;
        wdata = {rank_a_r, root_b_r};
      end else begin
        waddr = root_b_r;
        wdata = {rank_b_r, root_a_r};
      end
    end else if (cmd.rank_wr) begin
      we    = 1'b1;
      waddr = root_a_r;
      wdata = {rank_a_r + 1'b1, root_a_r};
    end
  end

  // parent/rank store, read address is always the cursor
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[cur_r];
  end

  // control-side registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r    <= kuf_pkg::VCOUNT_RESET;
      sweep_cnt_r <= '0;
      acc_r       <= '0;
    end else begin
      if (cfg_we) begin
        vcount_r <= cfg_wdata;
      end
      if (cmd.sweep_start) begin
        sweep_cnt_r <= '0;
      end else if (cmd.sweep_wr) begin
        sweep_cnt_r <= sweep_cnt_r + 1'b1;
      end
      if (cmd.clr_count) begin
        acc_r <= '0;
      end else if (cmd.count_inc) begin
        acc_r <= acc_r + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r   <= in_operation;
      a_r    <= in_vertex_a;
      b_r    <= in_vertex_b;
      last_r <= in_last_edge;
    end
    if (cmd.cur_load) begin
      cur_r <= cmd.sel_b ? b_idx : a_idx;
    end else if (cmd.walk_step || cmd.comp_wr) begin
      cur_r <= rd_parent;
    end
    if (cmd.root_save) begin
      if (cmd.sel_b) begin
        root_b_r <= cur_r;
        rank_b_r <= rd_rank;
      end else begin
        root_a_r <= cur_r;
        rank_a_r <= rd_rank;
      end
    end
    if (cmd.status_load) begin
      status_r <= cmd.status;
    end
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_tree_r   <= acc_r;
      out_fin_r    <= (status_r != kuf_pkg::ST_CLEARED) && (full_now || last_r);
    end
  end

  assign out_status     = out_status_r;
  assign out_tree_edges = out_tree_r;
  assign out_finished   = out_fin_r;

endmodule

>>> sv/kuf_ctrl.sv
// Controller: sequences clearing sweep, two root walks with path rewrite, and join.
module kuf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  kuf_pkg::stat_t stat,
  output kuf_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_CHECK, S_WALK_RD, S_WALK_CHK,
    S_COMP, S_COMP_WR, S_LOAD_B, S_JOIN, S_JOIN_RANK, S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   side_b_r, side_b_nxt;
  logic   report_r, report_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    side_b_nxt    = side_b_r;
    report_nxt    = report_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.sel_b     = side_b_r;
    cmd.status    = kuf_pkg::ST_ACCEPTED;
    unique case (state_r)
      S_SWEEP: begin
        cmd.sweep_wr = 1'b1;
        if (stat.sweep_last) begin
          cmd.clr_count = 1'b1;
          report_nxt    = 1'b0;
          if (report_r) begin
            cmd.status_load = 1'b1;
            cmd.status      = kuf_pkg::ST_CLEARED;
            state_nxt       = S_FINISH;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (stat.is_clear) begin
          cmd.sweep_start = 1'b1;
          report_nxt      = 1'b1;
          state_nxt       = S_SWEEP;
        end else if (stat.tree_full) begin
          cmd.status_load = 1'b1;
          cmd.status      = kuf_pkg::ST_FULL;
          state_nxt       = S_FINISH;
        end else if (stat.out_of_range) begin
          cmd.status_load = 1'b1;
          cmd.status      = kuf_pkg::ST_RANGE;
          state_nxt       = S_FINISH;
        end else begin
          cmd.cur_load = 1'b1;
          cmd.sel_b    = 1'b0;
          side_b_nxt   = 1'b0;
          state_nxt    = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        state_nxt = S_WALK_CHK;  // read of cursor in flight
      end
      S_WALK_CHK: begin
        if (stat.at_root) begin
          cmd.root_save = 1'b1;
          cmd.cur_load  = 1'b1;  // restart from the endpoint for the rewrite
          state_nxt     = S_COMP;
        end else begin
          cmd.walk_step = 1'b1;
          state_nxt     = S_WALK_RD;
        end
      end
      S_COMP: begin
        if (stat.cur_is_root) begin
          if (!side_b_r) begin
            side_b_nxt = 1'b1;
            state_nxt  = S_LOAD_B;
          end else if (stat.roots_equal) begin
            cmd.status_load = 1'b1;
            cmd.status      = kuf_pkg::ST_CYCLE;
            state_nxt       = S_FINISH;
          end else begin
            state_nxt = S_JOIN;
          end
        end else begin
          state_nxt = S_COMP_WR;
        end
      end
      S_COMP_WR: begin
        cmd.comp_wr = 1'b1;
        state_nxt   = S_COMP;
      end
      S_LOAD_B: begin
        cmd.cur_load = 1'b1;  // sel_b already follows side b
        state_nxt    = S_WALK_RD;
      end
      S_JOIN: begin
        cmd.join_wr     = 1'b1;
        cmd.count_inc   = 1'b1;
        cmd.status_load = 1'b1;
        cmd.status      = kuf_pkg::ST_ACCEPTED;
        if (stat.ranks_equal && !stat.rank_a_max) begin
          state_nxt = S_JOIN_RANK;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_JOIN_RANK: begin
        cmd.rank_wr = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      side_b_r    <= 1'b0;
      report_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      side_b_r    <= side_b_nxt;
      report_r    <= report_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> sv/kruskal_union_find_edge_filter.sv
// Kruskal edge filter: union-find by rank with path compression, top level.
//
// Usage: the sink channel in_ch takes one beat per operation. operation 0
// clears every set and the tree count; operation 1 offers an edge
// (vertex_a, vertex_b), edges in ascending weight order, last_edge on the
// final one. Every input beat yields exactly one beat on out_ch: status
// (accepted, cycle, tree full, out of range, cleared), tree_edges and
// finished. cfg_we/cfg_wdata write vertex_count (reset 256) while idle.
//
// Sequencing: one item at a time. An edge walks from each endpoint to its root
// and then re-points every link on that path at the root; each link is one
// memory read to find the root and one read plus one write to re-point it,
// over the store's single write port. An accepted edge whose two root ranks
// tie, below the maximum, also bumps the surviving root's rank. A full or
// out-of-range edge is rejected before any walk. A clear sweeps the store one
// entry per cycle.
//
// Reset: the same sweep runs with in_ch.ready low; it produces no result
// beat. The result sits in an output register, so a stalled receiver holds
// only the next finished result; the block keeps taking the following item
// and finishes it before waiting.
module kruskal_union_find_edge_filter #(
  parameter int MAX_VERTICES = kuf_pkg::MAX_VERTICES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  kuf_in_if.sink                       in_ch,
  kuf_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [kuf_pkg::COUNT_W-1:0]  cfg_wdata
);

  kuf_pkg::cmd_t  cmd;
  kuf_pkg::stat_t stat;

  // sequencer: handshakes, sweep, walk/rewrite/join order
  kuf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // store, cursor, roots, tree count and the result register
  kuf_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_operation   (in_ch.operation),
    .in_vertex_a    (in_ch.vertex_a),
    .in_vertex_b    (in_ch.vertex_b),
    .in_last_edge   (in_ch.last_edge),
    .cmd            (cmd),
    .stat           (stat),
    .out_status     (out_ch.status),
    .out_tree_edges (out_ch.tree_edges),
    .out_finished   (out_ch.finished)
  );

endmodule
